// ===== hw/rtl/utf8_to_utf16_transcoder_macros.svh =====
// Assertion macros shared by the transcoder RTL.
`ifndef UTF8_TO_UTF16_TRANSCODER_MACROS_SVH
`define UTF8_TO_UTF16_TRANSCODER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define U8U16_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define U8U16_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/u8u16_pkg.sv =====
// Types and constants for the UTF-8 to UTF-16 transcoder.
`default_nettype none

package u8u16_pkg;

  localparam int unsigned IN_TDATA_W  = 8;
  localparam int unsigned OUT_TDATA_W = 40;  // 16 + 3 + 16 bits, padded to bytes
  localparam int unsigned OUT_TUSER_W = 2;

  localparam logic [1:0] KIND_UNIT    = 2'd0;
  localparam logic [1:0] KIND_SUMMARY = 2'd1;
  localparam logic [1:0] KIND_ERROR   = 2'd2;

  localparam logic [2:0] ERR_NONE         = 3'd0;
  localparam logic [2:0] ERR_ILLEGAL_LEAD = 3'd1;
  localparam logic [2:0] ERR_TRUNCATED    = 3'd2;
  localparam logic [2:0] ERR_SURROGATE    = 3'd3;
  localparam logic [2:0] ERR_TOO_LARGE    = 3'd4;

  localparam logic [30:0] MAX_CODE_POINT = 31'h10FFFF;
  localparam logic [30:0] MAX_BMP        = 31'h00FFFF;
  localparam logic [19:0] SURR_HIGH_BITS = 20'h0001B;  // code[30:11] of 0xD800..0xDFFF
  localparam logic [15:0] LEAD_BASE      = 16'hD7C0;   // 0xD800 - (0x10000 >> 10)
  localparam logic [5:0]  TRAIL_TOP      = 6'b110111;  // 0xDC00 >> 10
  localparam logic [15:0] UNIT_CNT_MAX   = 16'hFFFF;

  typedef struct packed {
    logic [15:0] unit_value;
    logic [1:0]  item_kind;
    logic [2:0]  error_code;
    logic [15:0] units_total;
  } res_item_t;

endpackage

`default_nettype wire

// ===== hw/rtl/utf8_to_utf16_transcoder.sv =====
// UTF-8 byte stream to UTF-16 unit stream transcoder, top level.
//
//   channel   dir  tdata                                   tuser       tlast
//   s_axis    in   in_byte[7:0]                            -           end_of_string
//   m_axis    out  unit_value, error_code, units_total     item_kind   last_of_run
//
// Bytes pass an input register and a result register, one byte per cycle while m_axis
// does not stall and no byte yields more than one result. A byte holds the input register
// until its results (at most 3: a surrogate pair followed by the summary) are emitted.
// Reset (asynchronous) clears all decode state; there is no clearing pass.
// A stalled m_axis holds the result register; the input register still takes bytes that
// yield no results, and s_axis_tready drops once it holds a byte with a result to emit.
`default_nettype none

module utf8_to_utf16_transcoder (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  input  wire                               s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  input  wire  [u8u16_pkg::IN_TDATA_W-1:0]  s_axis_tdata_i,   // [7:0] in_byte
  input  wire                               s_axis_tlast_i,   // end_of_string
  output logic                              m_axis_tvalid_o,
  input  wire                               m_axis_tready_i,
  output logic [u8u16_pkg::OUT_TDATA_W-1:0] m_axis_tdata_o,   // [15:0] unit_value,
                                                              // [18:16] error_code,
                                                              // [34:19] units_total,
                                                              // [39:35] zero
  output logic [u8u16_pkg::OUT_TUSER_W-1:0] m_axis_tuser_o,   // [1:0] item_kind
  output logic                              m_axis_tlast_o    // last_of_run
);

  import u8u16_pkg::*;

  `include "utf8_to_utf16_transcoder_macros.svh"

  // input register
  logic        in_valid_q;
  logic [7:0]  in_byte_q;
  logic        in_eos_q;

  // decode state
  logic [2:0]  pending_q, pending_d;
  logic [30:0] acc_q, acc_d;
  logic [15:0] cnt_q, cnt_d;
  logic        errl_q, errl_d;

  // position within the current byte's results
  logic [1:0]  seq_q;

  // result register
  logic        out_valid_q;
  res_item_t   out_item_q;
  logic        out_last_q;

  // decode datapath
  logic [2:0]  lead_len;
  logic [30:0] acc_step;
  logic [2:0]  pend_step;
  logic        done;
  logic [2:0]  err;
  logic [15:0] cnt1, cnt2;
  logic [1:0]  n_res;
  res_item_t   item0, item1, item2, item_sel;

  logic        out_free, last_sel, emit, retire, in_accept;

  // leading ones after the top bit of a lead byte
  always_comb begin
    if (!in_byte_q[6])      lead_len = 3'd0;
    else if (!in_byte_q[5]) lead_len = 3'd1;
    else if (!in_byte_q[4]) lead_len = 3'd2;
    else if (!in_byte_q[3]) lead_len = 3'd3;
    else if (!in_byte_q[2]) lead_len = 3'd4;
    else if (!in_byte_q[1]) lead_len = 3'd5;
    else                    lead_len = 3'd6;
  end

  assign cnt1 = (cnt_q == UNIT_CNT_MAX) ? cnt_q : cnt_q + 16'd1;
  assign cnt2 = (cnt1  == UNIT_CNT_MAX) ? cnt1  : cnt1  + 16'd1;

  always_comb begin
    pending_d = pending_q;
    acc_d     = acc_q;
    cnt_d     = cnt_q;
    errl_d    = errl_q;
    acc_step  = acc_q;
    pend_step = pending_q;
    done      = 1'b0;
    err       = ERR_NONE;
    n_res     = 2'd0;
    item0     = '0;
    item1     = '0;
    item2     = '0;

    if (errl_q) begin
      // drop bytes until the end mark, which clears the string state
      if (in_eos_q) begin
        pending_d = '0;
        acc_d     = '0;
        cnt_d     = '0;
        errl_d    = 1'b0;
      end
    end else begin
      if (pending_q == 3'd0) begin
        if (!in_byte_q[7]) begin
          acc_step = {23'd0, in_byte_q};
          done     = 1'b1;
        end else if (lead_len == 3'd0 || lead_len == 3'd6) begin
          err = ERR_ILLEGAL_LEAD;
        end else begin
          acc_step  = {25'd0, in_byte_q[5:0] & (6'h3F >> lead_len)};
          pend_step = lead_len;
        end
      end else begin
        acc_step  = {acc_q[24:0], in_byte_q[5:0]};
        pend_step = pending_q - 3'd1;
        done      = (pending_q == 3'd1);
      end

      acc_d     = acc_step;
      pending_d = pend_step;

      if (done) begin
        acc_d = '0;
        if (acc_step[30:11] == SURR_HIGH_BITS) begin
          err = ERR_SURROGATE;
        end else if (acc_step > MAX_CODE_POINT) begin
          err = ERR_TOO_LARGE;
        end else if (acc_step <= MAX_BMP) begin
          cnt_d = cnt1;
          item0 = '{unit_value: acc_step[15:0], item_kind: KIND_UNIT,
                    error_code: ERR_NONE, units_total: cnt1};
          n_res = 2'd1;
        end else begin
          cnt_d = cnt2;
          item0 = '{unit_value: LEAD_BASE + {5'd0, acc_step[20:10]}, item_kind: KIND_UNIT,
                    error_code: ERR_NONE, units_total: cnt1};
          item1 = '{unit_value: {TRAIL_TOP, acc_step[9:0]}, item_kind: KIND_UNIT,
                    error_code: ERR_NONE, units_total: cnt2};
          n_res = 2'd2;
        end
      end

      if (err == ERR_NONE && in_eos_q && pend_step != 3'd0) begin
        err = ERR_TRUNCATED;
      end

      if (err != ERR_NONE) begin
        // an error never follows units of the same byte
        item0 = '{unit_value: 16'd0, item_kind: KIND_ERROR,
                  error_code: err, units_total: cnt_d};
        n_res = 2'd1;
        pending_d = '0;
        acc_d     = '0;
        if (in_eos_q) begin
          cnt_d = '0;
        end else begin
          errl_d = 1'b1;
        end
      end else if (in_eos_q) begin
        case (n_res)
          2'd0: item0 = '{unit_value: 16'd0, item_kind: KIND_SUMMARY,
                          error_code: ERR_NONE, units_total: cnt_d};
          2'd1: item1 = '{unit_value: 16'd0, item_kind: KIND_SUMMARY,
                          error_code: ERR_NONE, units_total: cnt_d};
          default: item2 = '{unit_value: 16'd0, item_kind: KIND_SUMMARY,
                             error_code: ERR_NONE, units_total: cnt_d};
        endcase
        n_res     = n_res + 2'd1;
        pending_d = '0;
        acc_d     = '0;
        cnt_d     = '0;
      end
    end
  end

  always_comb begin
    case (seq_q)
      2'd0:    item_sel = item0;
      2'd1:    item_sel = item1;
      default: item_sel = item2;
    endcase
  end

  assign out_free  = !out_valid_q || m_axis_tready_i;
  assign last_sel  = (seq_q == n_res - 2'd1);
  assign emit      = in_valid_q && (n_res != 2'd0) && out_free;
  assign retire    = in_valid_q && ((n_res == 2'd0) || (out_free && last_sel));
  assign in_accept = s_axis_tvalid_i && s_axis_tready_o;

  assign s_axis_tready_o = !in_valid_q || retire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      seq_q      <= 2'd0;
      pending_q  <= '0;
      acc_q      <= '0;
      cnt_q      <= '0;
      errl_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_accept) begin
        in_valid_q <= 1'b1;
      end else if (retire) begin
        in_valid_q <= 1'b0;
      end

      if (retire) begin
        seq_q     <= 2'd0;
        pending_q <= pending_d;
        acc_q     <= acc_d;
        cnt_q     <= cnt_d;
        errl_q    <= errl_d;
      end else if (emit) begin
        seq_q <= seq_q + 2'd1;
      end

      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_byte_q <= s_axis_tdata_i;
      in_eos_q  <= s_axis_tlast_i;
    end
    if (emit) begin
      out_item_q <= item_sel;
      out_last_q <= last_sel;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {5'd0, out_item_q.units_total, out_item_q.error_code,
                            out_item_q.unit_value};
  assign m_axis_tuser_o  = out_item_q.item_kind;
  assign m_axis_tlast_o  = out_last_q;

  `U8U16_ASSERT_NOW(a_seq_holds_byte, seq_q != 2'd0, in_valid_q,
                    "result sequence in progress without a held byte")
  `U8U16_ASSERT_NOW(a_report_is_last,
                    out_valid_q && out_item_q.item_kind != KIND_UNIT, out_last_q,
                    "summary or error report not marked last")
  `U8U16_ASSERT_NOW(a_latched_clean, errl_q, pending_q == 3'd0 && acc_q == 31'd0,
                    "decode state not cleared after error")
  `U8U16_ASSERT_NEXT(a_emit_shows, emit, out_valid_q,
                     "emitted result not presented")

endmodule

`default_nettype wire

// ===== verif/testbench.sv =====
// Testbench for the UTF-8 to UTF-16 transcoder: random strings, scoreboard, handshake mixes.
module testbench;
  import u8u16_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 50_000;
  localparam int unsigned RAND_PER_MIX = 60;       // minimum decoded bytes per handshake mix
  localparam logic [15:0] HI_SURR_BASE = 16'hD800 - 16'h0040;
  localparam logic [15:0] LO_SURR_BASE = 16'hDC00;
  localparam logic [30:0] SURR_FIRST   = 31'h00D800;
  localparam logic [30:0] SURR_LAST    = 31'h00DFFF;
  localparam logic [30:0] CODE_TOP     = 31'h10FFFF;
  localparam logic [30:0] BMP_TOP      = 31'h00FFFF;

  class u16_scoreboard;
    typedef struct {
      res_item_t item;
      bit        last;
    } unit_result_t;

    unit_result_t expected_q[$];
    logic [2:0]   cont_left;
    logic [30:0]  code_acc;
    logic [15:0]  units_seen;
    bit           dropping;
    int           mismatches;
    int           checked;
    int           decoded_bytes;

    function new();
      clear_string();
      mismatches    = 0;
      checked       = 0;
      decoded_bytes = 0;
    endfunction

    function void clear_string();
      cont_left  = '0;
      code_acc   = '0;
      units_seen = '0;
      dropping   = 1'b0;
    endfunction

    function void push_result(logic [15:0] unit, logic [1:0] kind, logic [2:0] code);
      unit_result_t r;
      if (kind == KIND_UNIT && units_seen != 16'hFFFF) units_seen++;
      r.item.unit_value  = unit;
      r.item.item_kind   = kind;
      r.item.error_code  = code;
      r.item.units_total = units_seen;
      r.last             = 1'b0;
      expected_q.push_back(r);
    endfunction

    // Accepted byte: update the decode state and queue the results it causes.
    function void note_byte(logic [7:0] b, bit eos);
      logic [2:0]  err;
      bit          done;
      int          n;
      int          first;
      logic [30:0] cp;
      err   = ERR_NONE;
      done  = 1'b0;
      first = expected_q.size();
      if (dropping) begin
        if (eos) clear_string();
        return;
      end
      decoded_bytes++;
      if (cont_left == 0) begin
        if (b[7]) begin
          n = 0;
          while (n < 7 && b[6-n]) n++;
          if (n == 0 || n >= 6) begin
            err = ERR_ILLEGAL_LEAD;
          end else begin
            code_acc  = 31'(b & (8'h3F >> n));
            cont_left = 3'(n);
          end
        end else begin
          code_acc = 31'(b);
          done     = 1'b1;
        end
      end else begin
        // top bits of a continuation byte are ignored
        code_acc = {code_acc[24:0], b[5:0]};
        cont_left--;
        if (cont_left == 0) done = 1'b1;
      end
      if (done) begin
        cp       = code_acc;
        code_acc = '0;
        if (cp >= SURR_FIRST && cp <= SURR_LAST) begin
          err = ERR_SURROGATE;
        end else if (cp > CODE_TOP) begin
          err = ERR_TOO_LARGE;
        end else if (cp <= BMP_TOP) begin
          push_result(cp[15:0], KIND_UNIT, ERR_NONE);
        end else begin
          push_result(HI_SURR_BASE + 16'(cp >> 10), KIND_UNIT, ERR_NONE);
          push_result(LO_SURR_BASE + {6'd0, cp[9:0]}, KIND_UNIT, ERR_NONE);
        end
      end
      if (err == ERR_NONE && eos && cont_left != 0) err = ERR_TRUNCATED;
      if (err != ERR_NONE) begin
        push_result(16'h0000, KIND_ERROR, err);
        if (eos) begin
          clear_string();
        end else begin
          dropping  = 1'b1;
          cont_left = '0;
          code_acc  = '0;
        end
      end else if (eos) begin
        push_result(16'h0000, KIND_SUMMARY, ERR_NONE);
        clear_string();
      end
      if (expected_q.size() > first) expected_q[expected_q.size()-1].last = 1'b1;
    endfunction

    task report_mismatch(string what, logic [15:0] got, logic [15:0] want);
      if (mismatches < 40)
        $display("mismatch at result %0d: %s got %h expected %h", checked, what, got, want);
      mismatches++;
    endtask

    task check_result(logic [OUT_TDATA_W-1:0] data, logic [OUT_TUSER_W-1:0] user,
                      logic last);
      unit_result_t want;
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected transfer, unit", data[15:0], 16'h0000);
        return;
      end
      want = expected_q.pop_front();
      checked++;
      if (data[15:0] !== want.item.unit_value)
        report_mismatch("unit_value", data[15:0], want.item.unit_value);
      if (user !== want.item.item_kind)
        report_mismatch("item_kind", 16'(user), 16'(want.item.item_kind));
      if (data[18:16] !== want.item.error_code)
        report_mismatch("error_code", 16'(data[18:16]), 16'(want.item.error_code));
      if (data[34:19] !== want.item.units_total)
        report_mismatch("units_total", data[34:19], want.item.units_total);
      if (last !== want.last)
        report_mismatch("last_of_run", 16'(last), 16'(want.last));
      if (data[39:35] !== 5'd0)
        report_mismatch("tdata padding", 16'(data[39:35]), 16'h0000);
    endtask
  endclass

  logic                   clk_i;
  logic                   rst_ni          = 1'b0;
  logic                   s_axis_tvalid_i = 1'b0;
  logic                   s_axis_tready_o;
  logic [IN_TDATA_W-1:0]  s_axis_tdata_i  = '0;
  logic                   s_axis_tlast_i  = 1'b0;
  logic                   m_axis_tvalid_o;
  logic                   m_axis_tready_i = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata_o;
  logic [OUT_TUSER_W-1:0] m_axis_tuser_o;
  logic                   m_axis_tlast_o;

  u16_scoreboard sb = new();
  int unsigned   cycle_count    = 0;
  int            src_idle_pct   = 0;
  int            sink_stall_pct = 0;
  int            strings_sent   = 0;

  utf8_to_utf16_transcoder u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, sb.expected_q.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  // Result side: check every transfer, then pick next cycle's tready.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i)
      sb.check_result(m_axis_tdata_o, m_axis_tuser_o, m_axis_tlast_o);
    m_axis_tready_i <= ($urandom_range(99) >= sink_stall_pct);
  end

  task automatic send_byte(input logic [7:0] b, input bit eos);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= b;
    s_axis_tlast_i  <= eos;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    sb.note_byte(b, eos);
  endtask

  task automatic send_string(input logic [7:0] q[$]);
    foreach (q[i]) send_byte(q[i], i == q.size() - 1);
    strings_sent++;
  endtask

  // Append cp encoded with n continuation bytes; a few continuations get random top bits.
  function automatic void put_code(ref logic [7:0] q[$], input int n, input logic [30:0] cp);
    logic [7:0] low6;
    q.push_back(~(8'hFF >> (n + 1)) | (8'(cp >> (6 * n)) & (8'h3F >> n)));
    for (int i = n - 1; i >= 0; i--) begin
      low6 = 8'(cp >> (6 * i)) & 8'h3F;
      if ($urandom_range(15) == 0) q.push_back({2'($urandom), low6[5:0]});
      else q.push_back({2'b10, low6[5:0]});
    end
  endfunction

  task automatic send_random_string();
    logic [7:0] q[$];
    int         nchars;
    int         r;
    int         n;
    bit         cut;
    nchars = $urandom_range(1, 6);
    cut    = 1'b0;
    for (int c = 0; c < nchars && !cut; c++) begin
      r = $urandom_range(99);
      if (r < 30) q.push_back(8'($urandom_range(0, 127)));
      else if (r < 47) put_code(q, 1, 31'($urandom >> 21));
      else if (r < 62) put_code(q, 2, 31'($urandom >> 16));
      else if (r < 74) put_code(q, 3, 31'($urandom_range(32'h10000, 32'h10FFFF)));
      else if (r < 79) put_code(q, 2, 31'($urandom_range(32'hD800, 32'hDFFF)));
      else if (r < 84) put_code(q, 3, 31'($urandom >> 11));
      else if (r < 87) put_code(q, 4, 31'($urandom >> 6));
      else if (r < 89) put_code(q, 5, 31'($urandom >> 1));
      else if (r < 93) begin
        if ($urandom_range(3) == 0) q.push_back(8'($urandom_range(254, 255)));
        else q.push_back(8'($urandom_range(128, 191)));
      end else if (r < 96) q.push_back(8'($urandom));
      else begin
        // string ends inside a multi-byte sequence
        n = $urandom_range(1, 5);
        put_code(q, n, 31'($urandom >> 1));
        repeat ($urandom_range(1, n)) void'(q.pop_back());
        cut = 1'b1;
      end
    end
    send_string(q);
  endtask

  initial begin
    int goal;
    int src_mix[4];
    int sink_mix[4];
    src_mix  = '{0, 62, 0, 8};
    sink_mix = '{0, 0, 62, 8};
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_string({8'h00, 8'h7F});
    send_string({8'hF0, 8'h9F, 8'h98, 8'h80});        // surrogate pair plus summary
    send_string({8'hFF});
    send_string({8'h80, 8'h41});                      // stray continuation as lead
    send_string({8'hED, 8'hA0, 8'h80, 8'h41});        // encoded surrogate, then dropped
    send_string({8'hF4, 8'h90, 8'h80, 8'h80});        // 0x110000
    send_string({8'hE2, 8'h82});
    send_string({8'hC3});                             // truncated on the lead byte
    send_string({8'hFE});

    for (int ph = 0; ph < 4; ph++) begin
      src_idle_pct   = src_mix[ph];
      sink_stall_pct = sink_mix[ph];
      goal = sb.decoded_bytes + RAND_PER_MIX;
      while (sb.decoded_bytes < goal) send_random_string();
    end
    s_axis_tvalid_i <= 1'b0;
    sink_stall_pct  = 0;

    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("ran %0d strings (%0d decoded bytes), directed corner cases plus random",
             strings_sent, sb.decoded_bytes);
    $display("checked %0d results over four handshake mixes, %0d mismatches", sb.checked,
             sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/u8u16_pkg.sv
hw/rtl/utf8_to_utf16_transcoder.sv
verif/testbench.sv
